@@ hdl/sliding_window_sender_macros.svh @@
// Assertion macros for the sliding window sender checker
`ifndef SLIDING_WINDOW_SENDER_MACROS_SVH
`define SLIDING_WINDOW_SENDER_MACROS_SVH

// check on every clock edge outside reset
`define SWS_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define SWS_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/swnd_pkg.sv @@
// Package: sizes, codes and transaction types of the sliding window sender
package swnd_pkg;

    localparam int WINDOW_LEN = 4;
    localparam int SEQ_BITS   = 3;
    localparam int SEQ_SPACE  = 1 << SEQ_BITS;
    localparam int DATA_BITS  = 32;
    localparam int THR_BITS   = 3;
    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(3);

    localparam logic [SEQ_BITS-1:0] WIN_OFS = SEQ_BITS'(WINDOW_LEN % SEQ_SPACE);

    typedef enum logic [1:0] {
        REQ_SEND    = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        TMR_LEAVE   = 2'd0,
        TMR_STOP    = 2'd1,
        TMR_RESTART = 2'd2
    } t_timer_cmd;

    typedef struct packed {
        t_req_type             req_type;
        logic                  ack_ok;
        logic [SEQ_BITS-1:0]   ack_number;
        logic [DATA_BITS-1:0]  payload;
    } t_req;

    // first field in the highest bits
    typedef struct packed {
        logic                  window_full;
        t_timer_cmd            timer_command;
        logic [DATA_BITS-1:0]  tx_data;
        logic [SEQ_BITS-1:0]   tx_sequence;
        logic                  tx_valid;
        logic                  send_accepted;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [SEQ_BITS-1:0]   addr;
        logic [DATA_BITS-1:0]  data;
    } t_store_wr;

    localparam int IN_BITS  = ((DATA_BITS + SEQ_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_BITS = (($bits(t_result) + 7) / 8) * 8;

endpackage

@@ hdl/sliding_window_sender.sv @@
// Top level: go-back-N sender with fast retransmit, stream ports and threshold register
//
// Takes one request transaction (send, ack, timeout) per clock while the master
// side accepts results, and returns exactly one result transaction for each, in
// order. A request is held in the input register; the window update and the
// result are computed from it and land in the result register. Throughput is
// one transaction per cycle while results are taken, set by the update loop on
// base, next and the duplicate count. The input register doubles as a skid stage:
// while a result waits on the master side, a new request is still taken if the
// input register is empty. The payload store is not cleared after reset. The
// duplicate-ack threshold resets to 3 and should be written only while the block is idle.
module sliding_window_sender (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] payload_word, [34:32] ack_number, [35] ack_checksum_ok, [39:36] zero
    input  logic [swnd_pkg::IN_BITS-1:0]      i_s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] send_accepted, [1] tx_valid, [4:2] tx_sequence, [36:5] tx_data,
    // [38:37] timer_command, [39] window_full
    output logic [swnd_pkg::OUT_BITS-1:0]     o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swnd_pkg::THR_BITS-1:0]     i_cfg_data
);
    import swnd_pkg::*;

    logic                  r_in_valid;
    t_req                  r_in_req;
    logic                  r_out_valid;
    t_result               r_out_res;
    logic [THR_BITS-1:0]   r_threshold;
    logic                  out_free;
    logic                  fire;
    logic                  in_take;
    t_req                  in_req;
    t_result               core_res;
    t_store_wr             store_wr;
    logic [SEQ_BITS-1:0]   rd_base;
    logic [DATA_BITS-1:0]  base_data;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || fire;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign in_req.req_type   = t_req_type'(i_s_axis_tuser);
    assign in_req.payload    = i_s_axis_tdata[DATA_BITS-1:0];
    assign in_req.ack_number = i_s_axis_tdata[DATA_BITS +: SEQ_BITS];
    assign in_req.ack_ok     = i_s_axis_tdata[DATA_BITS+SEQ_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_threshold <= THR_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req <= in_req;
        end
        if (fire) begin
            r_out_res <= core_res;
        end
    end

    swnd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (r_in_req),
        .i_threshold (r_threshold),
        .i_base_data (base_data),
        .o_rd_base   (rd_base),
        .o_wr        (store_wr),
        .o_result    (core_res)
    );

    swnd_store u_store (
        .i_clk   (i_clk),
        .i_wr    (store_wr),
        .i_raddr (rd_base),
        .o_rdata (base_data)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_BITS'(r_out_res);

endmodule

@@ hdl/swnd_store.sv @@
// Store of unacknowledged payloads, indexed by sequence number
module swnd_store (
    input  logic                              i_clk,
    input  swnd_pkg::t_store_wr               i_wr,
    input  logic [swnd_pkg::SEQ_BITS-1:0]     i_raddr,
    output logic [swnd_pkg::DATA_BITS-1:0]    o_rdata
);
    import swnd_pkg::*;

    logic [DATA_BITS-1:0] r_mem [SEQ_SPACE];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_wr.we && (i_wr.addr == i_raddr)) begin
            r_rdata <= i_wr.data;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/swnd_core.sv @@
// Window state: base, next, duplicate count, and the per-transaction result
module swnd_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  swnd_pkg::t_req                    i_req,
    input  logic [swnd_pkg::THR_BITS-1:0]     i_threshold,
    input  logic [swnd_pkg::DATA_BITS-1:0]    i_base_data,
    output logic [swnd_pkg::SEQ_BITS-1:0]     o_rd_base,
    output swnd_pkg::t_store_wr               o_wr,
    output swnd_pkg::t_result                 o_result
);
    import swnd_pkg::*;

    logic [SEQ_BITS-1:0] r_base;
    logic [SEQ_BITS-1:0] r_next;
    logic [THR_BITS-1:0] r_dup;
    logic [SEQ_BITS-1:0] n_base;
    logic [SEQ_BITS-1:0] n_next;
    logic [THR_BITS-1:0] n_dup;
    logic [SEQ_BITS-1:0] ack_plus;
    logic [SEQ_BITS-1:0] offset;
    logic                is_empty;
    logic                is_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_next <= '0;
            r_dup  <= '0;
        end else if (i_fire) begin
            r_base <= n_base;
            r_next <= n_next;
            r_dup  <= n_dup;
        end
    end

    assign is_empty  = (r_base == r_next);
    assign is_full   = (r_next == r_base + WIN_OFS);
    assign offset    = i_req.ack_number - r_base;
    assign ack_plus  = i_req.ack_number + SEQ_BITS'(1);
    assign o_rd_base = !i_rst_n ? '0 : (i_fire ? n_base : r_base);

    always_comb begin
        n_base   = r_base;
        n_next   = r_next;
        n_dup    = r_dup;
        o_wr     = '{we: 1'b0, addr: r_next, data: i_req.payload};
        o_result = '0;
        case (i_req.req_type)
            REQ_SEND: begin
                if (!is_full) begin
                    o_wr.we                = i_fire;
                    o_result.send_accepted = 1'b1;
                    o_result.tx_valid      = 1'b1;
                    o_result.tx_sequence   = r_next;
                    o_result.tx_data       = i_req.payload;
                    if (is_empty) begin
                        o_result.timer_command = TMR_RESTART;
                    end
                    n_next = r_next + SEQ_BITS'(1);
                end
            end
            REQ_ACK: begin
                if (!is_empty && i_req.ack_ok) begin
                    if (32'(offset) < WINDOW_LEN) begin
                        n_base = ack_plus;
                        o_result.timer_command = (ack_plus == r_next) ? TMR_STOP
                                                                     : TMR_RESTART;
                    end else begin
                        n_dup = r_dup + THR_BITS'(1);
                        if (n_dup == i_threshold) begin
                            n_dup                  = '0;
                            o_result.tx_valid      = 1'b1;
                            o_result.tx_sequence   = r_base;
                            o_result.tx_data       = i_base_data;
                            o_result.timer_command = TMR_RESTART;
                        end
                    end
                end
            end
            REQ_TIMEOUT: begin
                o_result.tx_valid      = 1'b1;
                o_result.tx_sequence   = r_base;
                o_result.tx_data       = i_base_data;
                o_result.timer_command = TMR_RESTART;
            end
            default: begin
            end
        endcase
        o_result.window_full = (n_next == n_base + WIN_OFS);
    end

endmodule

@@ hdl/swnd_checker.sv @@
// Port checker for the sliding window sender, bound to the top level
`include "sliding_window_sender_macros.svh"

module swnd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [swnd_pkg::OUT_BITS-1:0]     o_m_axis_tdata
);
    import swnd_pkg::*;

    `SWS_ASSERT_ALL(a_idle_after_reset, !i_rst_n |=> !o_m_axis_tvalid,
        "result valid right after reset")
    `SWS_ASSERT_RUN(a_hold_on_stall,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata),
        "result changed while stalled")
    `SWS_ASSERT_RUN(a_quiet_without_packet,
        o_m_axis_tvalid && !o_m_axis_tdata[1] |-> o_m_axis_tdata[36:2] == '0,
        "packet fields set without a packet")
    `SWS_ASSERT_RUN(a_accept_emits,
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> o_m_axis_tdata[1],
        "accepted send without a packet")

endmodule

bind sliding_window_sender swnd_checker u_swnd_checker (.*);
